FILE: design/mlbt_pkg.sv
// shared types and constants for the multi-led blink/timeout controller
// no dependencies
package mlbt_pkg;

   localparam int NUM_LEDS_DEF = 3;

   localparam logic [3:0] OP_COMMAND = 4'd0;
   localparam logic [3:0] OP_TICK    = 4'd1;
   localparam logic [3:0] OP_SET_TMO = 4'd2;
   localparam logic [3:0] OP_BATTERY = 4'd3;
   localparam logic [3:0] OP_CONNECT = 4'd4;
   localparam logic [3:0] OP_CHARGE  = 4'd5;
   localparam logic [3:0] OP_PAIR_CF = 4'd6;
   localparam logic [3:0] OP_PAIR_OK = 4'd7;
   localparam logic [3:0] OP_SLEEP   = 4'd8;
   localparam logic [3:0] OP_QUERY   = 4'd9;

   localparam logic [2:0] REG_BLINK_PERIOD = 3'd0;
   localparam logic [2:0] REG_DEF_TIMEOUT  = 3'd1;
   localparam logic [2:0] REG_TICK_MS      = 3'd2;
   localparam logic [2:0] REG_BATT_COLOR   = 3'd3;
   localparam logic [2:0] REG_ADV_COLOR    = 3'd4;
   localparam logic [2:0] REG_PAIR_COLOR   = 3'd5;

   localparam logic [25:0] MS_PER_SECOND   = 26'd1000;
   localparam logic [25:0] CHARGE_TMO_MS   = 26'd5000;
   localparam logic [23:0] CHARGE_RED      = 24'd20 << 16;
   localparam logic [23:0] CHARGE_GREEN    = 24'd20 << 8;

   typedef struct packed {
      logic [15:0] blink_period_ms;
      logic [25:0] default_timeout_ms;
      logic [9:0]  tick_ms;
      logic [23:0] battery_color;
      logic [23:0] advertising_color;
      logic [23:0] pair_confirm_color;
   } cfg_type;

   typedef struct packed {
      logic       kind;
      logic [3:0] index;
      logic [23:0] color;
      logic       blinking;
      logic       last;
   } result_type;

endpackage

FILE: design/mlbt_regs.sv
// apb-style configuration register file
// depends on mlbt_pkg
module mlbt_regs (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output mlbt_pkg::cfg_type   cfg
);
   import mlbt_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_sel;
   logic       wr_en;

   assign reg_sel    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_BLINK_PERIOD: cfg_in.blink_period_ms    = csr_pwdata[15:0];
            REG_DEF_TIMEOUT:  cfg_in.default_timeout_ms = csr_pwdata[25:0];
            REG_TICK_MS:      cfg_in.tick_ms            = csr_pwdata[9:0];
            REG_BATT_COLOR:   cfg_in.battery_color      = csr_pwdata[23:0];
            REG_ADV_COLOR:    cfg_in.advertising_color  = csr_pwdata[23:0];
            REG_PAIR_COLOR:   cfg_in.pair_confirm_color = csr_pwdata[23:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_BLINK_PERIOD: csr_prdata = {16'd0, cfg_ff.blink_period_ms};
         REG_DEF_TIMEOUT:  csr_prdata = {6'd0, cfg_ff.default_timeout_ms};
         REG_TICK_MS:      csr_prdata = {22'd0, cfg_ff.tick_ms};
         REG_BATT_COLOR:   csr_prdata = {8'd0, cfg_ff.battery_color};
         REG_ADV_COLOR:    csr_prdata = {8'd0, cfg_ff.advertising_color};
         REG_PAIR_COLOR:   csr_prdata = {8'd0, cfg_ff.pair_confirm_color};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_period_ms    <= 16'd500;
         cfg_ff.default_timeout_ms <= 26'd30000;
         cfg_ff.tick_ms            <= 10'd10;
         cfg_ff.battery_color      <= 24'hFF0000;
         cfg_ff.advertising_color  <= 24'h0000FF;
         cfg_ff.pair_confirm_color <= 24'h00FF00;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

FILE: design/mlbt_mul1000.sv
// shift-add multiplier: seconds times 1000, adding over the set bits of 1000 in turn
// depends on mlbt_pkg
module mlbt_mul1000 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] secs,
   output logic        done,
   output logic [25:0] product
);
   import mlbt_pkg::*;

   // 1000 = 1111101000b, bits 3,5,6,7,8,9
   logic [25:0] acc_ff, acc_in;
   logic [3:0]  bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic [15:0] secs_ff, secs_in;
   logic [25:0] term;

   assign term    = {10'd0, secs_ff} << bit_ff;
   assign done    = busy_ff && (bit_ff == 4'd9);
   assign product = acc_ff + term;

   always_comb begin
      acc_in  = acc_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      secs_in = secs_ff;
      if (start) begin
         acc_in  = 26'd0;
         bit_in  = 4'd3;
         busy_in = 1'b1;
         secs_in = secs;
      end else if (busy_ff) begin
         if (MS_PER_SECOND[bit_ff]) acc_in = acc_ff + term;
         if (bit_ff == 4'd9) busy_in = 1'b0;
         else bit_in = bit_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         bit_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         bit_ff  <= bit_in;
      end
      acc_ff  <= acc_in;
      secs_ff <= secs_in;
   end
endmodule

FILE: design/multi_led_blink_timeout_controller_core.sv
// multi-led indicator controller: top level with event sequencer and led state
// depends on mlbt_pkg, mlbt_regs, mlbt_mul1000
//
// usage: one event beat enters on req_*; it produces zero to NUM_LEDS result
// beats on rsp_*, the last one flagged by rsp_last_of_run. events are handled
// one at a time: req_ready is high only while the sequencer is idle.
// a sequencer walks the leds one per cycle while the output is free (ticks and the
// pairing and sleep broadcasts), with a shared shift-add unit that scales seconds
// to ms. a tick walks every led, then a done state; a command with seconds, or a
// set-timeout to a valid led, waits on the multiplier. each result waits in a single
// output register, tick beats first in a holding register; while it is full and
// rsp_ready is low the walk stops at that led and resumes when the beat is taken.
// reset (synchronous, active high) clears all led state, flags and the csr
// registers to their defaults; no clearing pass is needed.
// the csr port is apb-style, pready always high, registers at 4*i.
module multi_led_blink_timeout_controller_core #(
   parameter int NUM_LEDS = mlbt_pkg::NUM_LEDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_operation,
   input  logic [3:0]  req_led_index,
   input  logic        req_turn_on,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [15:0] req_timeout_seconds,
   input  logic        req_blink_enable,
   input  logic [15:0] req_blink_half_period,
   input  logic        req_event_flag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_reply_kind,
   output logic [3:0]  rsp_out_index,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic        rsp_out_blinking,
   output logic        rsp_last_of_run,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mlbt_pkg::*;

   localparam int IW = $clog2(NUM_LEDS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_WALK = 3'd2;
   localparam logic [2:0] ST_DONE = 3'd4;

   cfg_type cfg;

   mlbt_regs u_regs (
      .clock(clock), .reset(reset),
      .csr_psel(psel), .csr_penable(penable), .csr_pwrite(pwrite),
      .csr_paddr(paddr), .csr_pwdata(pwdata), .csr_prdata(prdata),
      .csr_pready(pready), .cfg(cfg)
   );

   // led state
   logic [23:0] color_ff   [NUM_LEDS];
   logic [23:0] color_in   [NUM_LEDS];
   logic        bact_ff    [NUM_LEDS];
   logic        bact_in    [NUM_LEDS];
   logic        blit_ff    [NUM_LEDS];
   logic        blit_in    [NUM_LEDS];
   logic [15:0] blim_ff    [NUM_LEDS];
   logic [15:0] blim_in    [NUM_LEDS];
   logic [16:0] bela_ff    [NUM_LEDS];
   logic [16:0] bela_in    [NUM_LEDS];
   logic        tarm_ff    [NUM_LEDS];
   logic        tarm_in    [NUM_LEDS];
   logic [25:0] tleft_ff   [NUM_LEDS];
   logic [25:0] tleft_in   [NUM_LEDS];
   logic        batt_ff, batt_in, pair_ff, pair_in;

   // latched event
   logic [3:0]  op_ff, op_in;
   logic [3:0]  idx_ff, idx_in;
   logic        on_ff, on_in, ben_ff, ben_in, flag_ff, flag_in;
   logic [23:0] rgb_ff, rgb_in;
   logic [15:0] secs_ff, secs_in, half_ff, half_in;
   logic [2:0]  state_ff, state_in;
   logic [IW:0] led_ff, led_in;
   logic        any_ff, any_in;

   // output register
   logic        ovalid_ff, ovalid_in;
   result_type  ores_ff, ores_in;

   logic        mul_start, mul_done;
   logic [25:0] mul_product;

   mlbt_mul1000 u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .secs(secs_ff),
      .done(mul_done), .product(mul_product)
   );

   logic        accept;
   logic        out_free;
   logic [IW-1:0] cur;
   logic        idx_valid;
   logic [IW-1:0] idx_led;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !ovalid_ff || rsp_ready;
   assign cur       = led_ff[IW-1:0];
   assign idx_valid = ({{(8-4){1'b0}}, idx_ff} < 8'(NUM_LEDS));
   assign idx_led   = idx_ff[IW-1:0];

   assign rsp_valid        = ovalid_ff;
   assign rsp_reply_kind   = ores_ff.kind;
   assign rsp_out_index    = ores_ff.index;
   assign rsp_out_red      = ores_ff.color[23:16];
   assign rsp_out_green    = ores_ff.color[15:8];
   assign rsp_out_blue     = ores_ff.color[7:0];
   assign rsp_out_blinking = ores_ff.blinking;
   assign rsp_last_of_run  = ores_ff.last;

   // tick step of the current led: shared subtract/compare datapath
   logic        t_active, t_fire, t_blk, t_tog;
   logic [25:0] t_sub;
   logic [16:0] t_ela;
   logic        t_lit;
   logic [10:0] tick_w;
   logic        is_last_led;

   assign is_last_led = (led_ff == (IW+1)'(NUM_LEDS - 1));

   always_comb begin
      tick_w   = {1'b0, cfg.tick_ms};
      t_active = tarm_ff[cur] && (tleft_ff[cur] != 26'd0) && (cfg.tick_ms != 10'd0);
      t_sub    = tleft_ff[cur] - {16'd0, cfg.tick_ms};
      t_fire   = t_active && (tleft_ff[cur] <= {16'd0, cfg.tick_ms})
                 && !(cur == '0 && batt_ff);
      t_blk    = !t_fire && bact_ff[cur] && (blim_ff[cur] != 16'd0);
      t_ela    = bela_ff[cur] + {6'd0, tick_w};
      t_tog    = t_blk && (t_ela >= {1'b0, blim_ff[cur]});
      t_lit    = !blit_ff[cur];
   end

   always_comb begin
      for (int k = 0; k < NUM_LEDS; k++) begin
         color_in[k] = color_ff[k];
         bact_in[k]  = bact_ff[k];
         blit_in[k]  = blit_ff[k];
         blim_in[k]  = blim_ff[k];
         bela_in[k]  = bela_ff[k];
         tarm_in[k]  = tarm_ff[k];
         tleft_in[k] = tleft_ff[k];
      end
      batt_in   = batt_ff;
      pair_in   = pair_ff;
      op_in     = op_ff;
      idx_in    = idx_ff;
      on_in     = on_ff;
      ben_in    = ben_ff;
      flag_in   = flag_ff;
      rgb_in    = rgb_ff;
      secs_in   = secs_ff;
      half_in   = half_ff;
      state_in  = state_ff;
      led_in    = led_ff;
      any_in    = any_ff;
      mul_start = 1'b0;
      ovalid_in = ovalid_ff && !rsp_ready;
      ores_in   = ores_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_operation;
               idx_in  = req_led_index;
               on_in   = req_turn_on;
               ben_in  = req_blink_enable;
               flag_in = req_event_flag;
               rgb_in  = {req_red, req_green, req_blue};
               secs_in = req_timeout_seconds;
               half_in = req_blink_half_period;
               led_in  = '0;
               any_in  = 1'b0;
               state_in = ST_WALK;
            end
         end
         ST_MUL: begin
            // product ready; commit the timer
            if (mul_done) begin
               tarm_in[idx_led]  = (mul_product != 26'd0);
               tleft_in[idx_led] = mul_product;
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (out_free) begin
               unique case (op_ff)
                  OP_COMMAND: begin
                     state_in = ST_IDLE;
                     if (idx_valid && !(idx_led == '0 && batt_ff)) begin
                        tarm_in[idx_led]  = 1'b0;
                        tleft_in[idx_led] = 26'd0;
                        bela_in[idx_led]  = 17'd0;
                        ovalid_in = 1'b1;
                        ores_in   = '{kind: 1'b0, index: idx_ff, color: 24'd0,
                                      blinking: 1'b0, last: 1'b1};
                        if (!on_ff) begin
                           bact_in[idx_led]  = 1'b0;
                           blit_in[idx_led]  = 1'b0;
                           color_in[idx_led] = 24'd0;
                        end else begin
                           color_in[idx_led] = rgb_ff;
                           bact_in[idx_led]  = ben_ff;
                           blim_in[idx_led]  = (half_ff != 16'd0) ? half_ff
                                               : cfg.blink_period_ms;
                           blit_in[idx_led]  = 1'b1;
                           ores_in.color     = rgb_ff;
                           if (secs_ff == 16'd0) begin
                              tarm_in[idx_led]  = (cfg.default_timeout_ms != 26'd0);
                              tleft_in[idx_led] = cfg.default_timeout_ms;
                           end else begin
                              mul_start = 1'b1;
                              state_in  = ST_MUL;
                           end
                        end
                     end
                  end
                  OP_SET_TMO: begin
                     if (idx_valid) begin
                        mul_start = 1'b1;
                        state_in  = ST_MUL;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  OP_TICK: begin
                     // one led per cycle while the output is free; results gathered in led order
                     if (t_active) begin
                        if (tleft_ff[cur] <= {16'd0, cfg.tick_ms}) begin
                           tleft_in[cur] = 26'd0;
                        end else begin
                           tleft_in[cur] = t_sub;
                        end
                     end
                     if (t_fire) begin
                        bact_in[cur] = 1'b0;
                        bela_in[cur] = 17'd0;
                        blit_in[cur] = 1'b0;
                        tarm_in[cur] = 1'b0;
                        ovalid_in = 1'b1;
                        ores_in   = '{kind: 1'b0, index: 4'(cur), color: 24'd0,
                                      blinking: 1'b0, last: 1'b0};
                     end else if (t_blk) begin
                        if (t_tog) begin
                           bela_in[cur] = 17'd0;
                           blit_in[cur] = t_lit;
                           ovalid_in = 1'b1;
                           ores_in   = '{kind: 1'b0, index: 4'(cur),
                                         color: t_lit ? color_ff[cur] : 24'd0,
                                         blinking: 1'b0, last: 1'b0};
                        end else begin
                           bela_in[cur] = t_ela;
                        end
                     end
                     // last flag goes on the final beat; held one beat back
                     if (is_last_led) state_in = ST_DONE;
                     else led_in = led_ff + 1'b1;
                  end
                  OP_BATTERY: begin
                     batt_in  = flag_ff;
                     state_in = ST_IDLE;
                     if (flag_ff) begin
                        tarm_in[0]  = 1'b0;
                        tleft_in[0] = 26'd0;
                        color_in[0] = cfg.battery_color;
                        bact_in[0]  = 1'b1;
                        blim_in[0]  = cfg.blink_period_ms;
                        bela_in[0]  = 17'd0;
                        blit_in[0]  = 1'b0;
                     end else begin
                        bact_in[0] = 1'b0;
                        if (!tarm_ff[0]) begin
                           color_in[0] = 24'd0;
                           ovalid_in = 1'b1;
                           ores_in   = '{kind: 1'b0, index: 4'd0, color: 24'd0,
                                         blinking: 1'b0, last: 1'b1};
                        end
                     end
                  end
                  OP_CONNECT: begin
                     if (led_ff == '0) begin
                        if (flag_ff) begin
                           bact_in[2] = 1'b0;
                           bela_in[2] = 17'd0;
                           blit_in[2] = 1'b0;
                           ovalid_in = 1'b1;
                           ores_in   = '{kind: 1'b0, index: 4'd2, color: 24'd0,
                                         blinking: 1'b0, last: 1'b1};
                           state_in = ST_IDLE;
                        end else begin
                           tarm_in[2]  = 1'b0;
                           tleft_in[2] = 26'd0;
                           color_in[2] = cfg.advertising_color;
                           bact_in[2]  = 1'b1;
                           blim_in[2]  = cfg.blink_period_ms;
                           bela_in[2]  = 17'd0;
                           blit_in[2]  = 1'b0;
                           if (pair_ff) begin
                              ovalid_in = 1'b1;
                              ores_in   = '{kind: 1'b0, index: 4'd0, color: 24'd0,
                                            blinking: 1'b0, last: 1'b0};
                              led_in = led_ff + 1'b1;
                           end else begin
                              state_in = ST_IDLE;
                           end
                        end
                     end else begin
                        ovalid_in = 1'b1;
                        ores_in   = '{kind: 1'b0, index: 4'd1, color: 24'd0,
                                      blinking: 1'b0, last: 1'b1};
                        state_in = ST_IDLE;
                     end
                  end
                  OP_CHARGE: begin
                     for (int k = 0; k < NUM_LEDS; k++) begin
                        color_in[k] = flag_ff ? CHARGE_RED : CHARGE_GREEN;
                        bact_in[k]  = 1'b1;
                        blim_in[k]  = cfg.blink_period_ms;
                        bela_in[k]  = 17'd0;
                        blit_in[k]  = 1'b0;
                        tarm_in[k]  = 1'b1;
                        tleft_in[k] = CHARGE_TMO_MS;
                     end
                     state_in = ST_IDLE;
                  end
                  OP_PAIR_CF, OP_PAIR_OK: begin
                     if (led_ff == '0) begin
                        for (int k = 0; k < NUM_LEDS; k++) begin
                           tarm_in[k]  = 1'b0;
                           tleft_in[k] = 26'd0;
                           bact_in[k]  = 1'b0;
                           if (op_ff == OP_PAIR_OK) color_in[k] = 24'd0;
                        end
                        pair_in = (op_ff == OP_PAIR_CF);
                        if (op_ff == OP_PAIR_OK) batt_in = 1'b0;
                     end
                     ovalid_in = 1'b1;
                     ores_in   = '{kind: 1'b0, index: 4'(cur),
                                   color: (op_ff == OP_PAIR_CF) ? cfg.pair_confirm_color
                                                               : 24'd0,
                                   blinking: 1'b0, last: is_last_led};
                     if (is_last_led) state_in = ST_IDLE;
                     else led_in = led_ff + 1'b1;
                  end
                  OP_SLEEP: begin
                     if (flag_ff) begin
                        tarm_in[cur]  = 1'b0;
                        tleft_in[cur] = 26'd0;
                        bact_in[cur]  = 1'b0;
                        bela_in[cur]  = 17'd0;
                        ovalid_in = 1'b1;
                        ores_in   = '{kind: 1'b0, index: 4'(cur), color: 24'd0,
                                      blinking: 1'b0, last: is_last_led};
                        if (is_last_led) state_in = ST_IDLE;
                        else led_in = led_ff + 1'b1;
                     end else begin
                        tarm_in[2]  = 1'b0;
                        tleft_in[2] = 26'd0;
                        color_in[2] = cfg.advertising_color;
                        bact_in[2]  = 1'b1;
                        blim_in[2]  = cfg.blink_period_ms;
                        bela_in[2]  = 17'd0;
                        blit_in[2]  = 1'b1;
                        ovalid_in = 1'b1;
                        ores_in   = '{kind: 1'b0, index: 4'd2,
                                      color: cfg.advertising_color,
                                      blinking: 1'b0, last: 1'b1};
                        state_in = ST_IDLE;
                     end
                  end
                  OP_QUERY: begin
                     ovalid_in = 1'b1;
                     ores_in   = '{kind: 1'b1, index: idx_ff,
                                   color: idx_valid ? color_ff[idx_led] : 24'd0,
                                   blinking: idx_valid ? bact_ff[idx_led] : 1'b0,
                                   last: 1'b1};
                     state_in = ST_IDLE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // tick beats are emitted without a last flag; a held beat is released with
   // last set when the walk ends. the tick walk pends each beat in a one-entry
   // holding register
   logic        hold_ff, hold_in;
   result_type  hres_ff, hres_in;
   logic        tick_walk;
   logic        tick_new;
   logic        ovalid_fin;
   result_type  ores_fin;

   assign tick_walk = (state_ff == ST_WALK) && (op_ff == OP_TICK);
   assign tick_new  = tick_walk && out_free && (t_fire || t_tog);

   always_comb begin
      hold_in    = hold_ff;
      hres_in    = hres_ff;
      ovalid_fin = ovalid_in;
      ores_fin   = ores_in;
      if (tick_walk) begin
         // keep output untouched by walk; move held beat out on new beat
         ovalid_fin = ovalid_ff && !rsp_ready;
         ores_fin   = ores_ff;
         if (tick_new) begin
            if (hold_ff) begin
               ovalid_fin = 1'b1;
               ores_fin   = hres_ff;
            end
            hold_in = 1'b1;
            hres_in = ores_in;
         end
      end else if (state_ff == ST_DONE) begin
         ovalid_fin = ovalid_ff && !rsp_ready;
         ores_fin   = ores_ff;
         if (hold_ff) begin
            if (out_free) begin
               ovalid_fin   = 1'b1;
               ores_fin     = hres_ff;
               ores_fin.last = 1'b1;
               hold_in = 1'b0;
            end
         end
      end
   end

   logic [2:0] state_fin;
   // stay in done until the held beat has gone out
   assign state_fin = (state_ff == ST_DONE && hold_ff && !out_free) ? ST_DONE : state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_LEDS; k++) begin
            color_ff[k] <= 24'd0;
            bact_ff[k]  <= 1'b0;
            blit_ff[k]  <= 1'b0;
            blim_ff[k]  <= 16'd0;
            bela_ff[k]  <= 17'd0;
            tarm_ff[k]  <= 1'b0;
            tleft_ff[k] <= 26'd0;
         end
         batt_ff   <= 1'b0;
         pair_ff   <= 1'b0;
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
         hold_ff   <= 1'b0;
         led_ff    <= '0;
         any_ff    <= 1'b0;
      end else begin
         for (int k = 0; k < NUM_LEDS; k++) begin
            color_ff[k] <= color_in[k];
            bact_ff[k]  <= bact_in[k];
            blit_ff[k]  <= blit_in[k];
            blim_ff[k]  <= blim_in[k];
            bela_ff[k]  <= bela_in[k];
            tarm_ff[k]  <= tarm_in[k];
            tleft_ff[k] <= tleft_in[k];
         end
         batt_ff   <= batt_in;
         pair_ff   <= pair_in;
         state_ff  <= state_fin;
         ovalid_ff <= ovalid_fin;
         hold_ff   <= hold_in;
         led_ff    <= led_in;
         any_ff    <= any_in || tick_new;
      end
      op_ff   <= op_in;
      idx_ff  <= idx_in;
      on_ff   <= on_in;
      ben_ff  <= ben_in;
      flag_ff <= flag_in;
      rgb_ff  <= rgb_in;
      secs_ff <= secs_in;
      half_ff <= half_in;
      ores_ff <= ores_fin;
      hres_ff <= hres_in;
   end

   // a held tick beat only exists during a tick walk or its wrap-up
   assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> (state_ff == ST_WALK || state_ff == ST_DONE))
      else $error("held beat outside tick walk");
   // a new event is never taken while a beat is held back
   assert property (@(posedge clock) disable iff (reset)
      accept |-> !hold_ff)
      else $error("event accepted with pending beat");
   // the multiplier only runs while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL))
      else $error("multiplier finished outside wait state");
   // the held beat was marked as seen in this walk
   assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> any_ff)
      else $error("held beat without a recorded result");

endmodule

FILE: bench/testbench.sv
// self-checking bench for multi_led_blink_timeout_controller_core: directed and random events,
// csr setups over the apb port, random stalls on both channels and an in-bench led predictor
// depends on mlbt_pkg and the core rtl only
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mlbt_pkg::*;

   localparam int LEDS = 3;
   localparam int LIMIT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [3:0]  operation;
      logic [3:0]  led_index;
      logic        turn_on;
      logic [7:0]  red, green, blue;
      logic [15:0] timeout_seconds;
      logic        blink_enable;
      logic [15:0] blink_half_period;
      logic        event_flag;
   } led_event_type;

   typedef struct {
      logic       kind;
      logic [3:0] index;
      logic [7:0] red, green, blue;
      logic       blinking;
      logic       last;
   } led_beat_type;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [3:0]  req_operation, req_led_index;
   logic        req_turn_on, req_blink_enable, req_event_flag;
   logic [7:0]  req_red, req_green, req_blue;
   logic [15:0] req_timeout_seconds, req_blink_half_period;
   logic        rsp_valid, rsp_ready, rsp_reply_kind, rsp_out_blinking, rsp_last_of_run;
   logic [3:0]  rsp_out_index;
   logic [7:0]  rsp_out_red, rsp_out_green, rsp_out_blue;
   logic        psel, penable, pwrite, pready;
   logic [4:0]  paddr;
   logic [31:0] pwdata, prdata;

   int          error_count = 0;
   int          cycle_count = 0;
   bit          no_idle = 0;
   int          hold_request = 0;
   int          hold_left = 0;
   led_beat_type expected_beats[$];
   led_beat_type run_beats[$];

   // predictor state
   logic [7:0]  led_r[LEDS], led_g[LEDS], led_b[LEDS];
   bit          blinking[LEDS], lit[LEDS], armed[LEDS];
   int unsigned blink_lim[LEDS], blink_acc[LEDS], left_ms[LEDS];
   bit          batt_low, pairing;
   int unsigned period_ms, def_tmo_ms, tick_step;
   logic [23:0] batt_color, adv_color, pair_color;

   multi_led_blink_timeout_controller_core dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 37);
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      led_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat index", rsp_out_index, 0);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_reply_kind !== want.kind) report_mismatch("kind", rsp_reply_kind, want.kind);
            if (rsp_out_index !== want.index) report_mismatch("index", rsp_out_index, want.index);
            if (rsp_out_red !== want.red) report_mismatch("red", rsp_out_red, want.red);
            if (rsp_out_green !== want.green) report_mismatch("green", rsp_out_green, want.green);
            if (rsp_out_blue !== want.blue) report_mismatch("blue", rsp_out_blue, want.blue);
            if (rsp_out_blinking !== want.blinking)
               report_mismatch("blinking", rsp_out_blinking, want.blinking);
            if (rsp_last_of_run !== want.last) report_mismatch("last", rsp_last_of_run, want.last);
         end
      end
   end

   function automatic void push_beat(bit kind, int i, logic [7:0] r, logic [7:0] g,
                                     logic [7:0] b, bit blink_flag);
      led_beat_type nb;
      nb.kind = kind;
      nb.index = i[3:0];
      nb.red = r;
      nb.green = g;
      nb.blue = b;
      nb.blinking = blink_flag;
      nb.last = 0;
      run_beats.push_back(nb);
   endfunction

   function automatic void set_packed(int i, logic [23:0] c);
      led_r[i] = c[23:16];
      led_g[i] = c[15:8];
      led_b[i] = c[7:0];
   endfunction

   function automatic void arm_timer(int i, int unsigned ms);
      armed[i] = (ms != 0);
      left_ms[i] = ms;
   endfunction

   function automatic void start_blink(int i, logic [23:0] c, bit lit_now);
      set_packed(i, c);
      blinking[i] = 1;
      blink_lim[i] = period_ms;
      blink_acc[i] = 0;
      lit[i] = lit_now;
   endfunction

   function automatic void reset_predictor();
      period_ms = 500;
      def_tmo_ms = 30000;
      tick_step = 10;
      batt_color = 24'hFF0000;
      adv_color = 24'h0000FF;
      pair_color = 24'h00FF00;
      for (int i = 0; i < LEDS; i++) begin
         set_packed(i, 24'd0);
         blinking[i] = 0;
         lit[i] = 0;
         armed[i] = 0;
         blink_lim[i] = 0;
         blink_acc[i] = 0;
         left_ms[i] = 0;
      end
      batt_low = 0;
      pairing = 0;
   endfunction

   function automatic void advance_tick();
      for (int i = 0; i < LEDS; i++) begin
         if (armed[i] && left_ms[i] != 0 && tick_step != 0) begin
            if (left_ms[i] <= tick_step) begin
               left_ms[i] = 0;
               // led0 expiry is swallowed while the battery is low
               if (!(i == 0 && batt_low)) begin
                  push_beat(0, i, 0, 0, 0, 0);
                  blinking[i] = 0;
                  blink_acc[i] = 0;
                  lit[i] = 0;
                  armed[i] = 0;
               end
            end else begin
               left_ms[i] -= tick_step;
            end
         end
         if (blinking[i] && blink_lim[i] != 0) begin
            blink_acc[i] += tick_step;
            if (blink_acc[i] >= blink_lim[i]) begin
               blink_acc[i] = 0;
               lit[i] = !lit[i];
               if (lit[i]) push_beat(0, i, led_r[i], led_g[i], led_b[i], 0);
               else push_beat(0, i, 0, 0, 0, 0);
            end
         end
      end
   endfunction

   function automatic void predict_led_event(led_event_type e);
      bit ok;
      int i;
      ok = e.led_index < LEDS;
      i = ok ? int'(e.led_index) : 0;
      run_beats.delete();
      case (e.operation)
         OP_COMMAND: begin
            if (ok && !(i == 0 && batt_low)) begin
               armed[i] = 0;
               left_ms[i] = 0;
               blink_acc[i] = 0;
               if (!e.turn_on) begin
                  push_beat(0, i, 0, 0, 0, 0);
                  blinking[i] = 0;
                  lit[i] = 0;
                  set_packed(i, 24'd0);
               end else begin
                  set_packed(i, {e.red, e.green, e.blue});
                  blinking[i] = e.blink_enable;
                  blink_lim[i] = e.blink_half_period != 0 ? e.blink_half_period : period_ms;
                  lit[i] = 1;
                  push_beat(0, i, e.red, e.green, e.blue, 0);
                  arm_timer(i, e.timeout_seconds != 0 ? e.timeout_seconds * 1000 : def_tmo_ms);
               end
            end
         end
         OP_TICK: advance_tick();
         OP_SET_TMO: if (ok) arm_timer(i, e.timeout_seconds * 1000);
         OP_BATTERY: begin
            batt_low = e.event_flag;
            if (e.event_flag) begin
               arm_timer(0, 0);
               start_blink(0, batt_color, 0);
            end else begin
               blinking[0] = 0;
               if (!armed[0]) begin
                  push_beat(0, 0, 0, 0, 0, 0);
                  set_packed(0, 24'd0);
               end
            end
         end
         OP_CONNECT: begin
            if (e.event_flag) begin
               blinking[2] = 0;
               blink_acc[2] = 0;
               lit[2] = 0;
               push_beat(0, 2, 0, 0, 0, 0);
            end else begin
               arm_timer(2, 0);
               start_blink(2, adv_color, 0);
               if (pairing) begin
                  push_beat(0, 0, 0, 0, 0, 0);
                  push_beat(0, 1, 0, 0, 0, 0);
               end
            end
         end
         OP_CHARGE: begin
            for (int k = 0; k < LEDS; k++) begin
               start_blink(k, e.event_flag ? CHARGE_RED : CHARGE_GREEN, 0);
               arm_timer(k, 5000);
            end
         end
         OP_PAIR_CF: begin
            for (int k = 0; k < LEDS; k++) begin
               arm_timer(k, 0);
               blinking[k] = 0;
            end
            for (int k = 0; k < LEDS; k++)
               push_beat(0, k, pair_color[23:16], pair_color[15:8], pair_color[7:0], 0);
            pairing = 1;
         end
         OP_PAIR_OK: begin
            for (int k = 0; k < LEDS; k++) begin
               arm_timer(k, 0);
               blinking[k] = 0;
               set_packed(k, 24'd0);
            end
            for (int k = 0; k < LEDS; k++) push_beat(0, k, 0, 0, 0, 0);
            batt_low = 0;
            pairing = 0;
         end
         OP_SLEEP: begin
            if (e.event_flag) begin
               for (int k = 0; k < LEDS; k++) push_beat(0, k, 0, 0, 0, 0);
               for (int k = 0; k < LEDS; k++) begin
                  arm_timer(k, 0);
                  blinking[k] = 0;
                  blink_acc[k] = 0;
               end
            end else begin
               arm_timer(2, 0);
               start_blink(2, adv_color, 1);
               push_beat(0, 2, led_r[2], led_g[2], led_b[2], 0);
            end
         end
         OP_QUERY: begin
            if (ok) push_beat(1, i, led_r[i], led_g[i], led_b[i], blinking[i]);
            else push_beat(1, e.led_index, 0, 0, 0, 0);
         end
         default: ;
      endcase
      if (run_beats.size() > 0) run_beats[run_beats.size() - 1].last = 1;
      foreach (run_beats[n]) expected_beats.push_back(run_beats[n]);
   endfunction

   task automatic send_event(led_event_type e);
      if (!no_idle && $urandom_range(99) < 37) repeat ($urandom_range(1, 4)) @(posedge clock);
      @(posedge clock);
      req_valid <= 1'b1;
      req_operation <= e.operation;
      req_led_index <= e.led_index;
      req_turn_on <= e.turn_on;
      req_red <= e.red;
      req_green <= e.green;
      req_blue <= e.blue;
      req_timeout_seconds <= e.timeout_seconds;
      req_blink_enable <= e.blink_enable;
      req_blink_half_period <= e.blink_half_period;
      req_event_flag <= e.event_flag;
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
      predict_led_event(e);
   endtask

   function automatic led_event_type make_event(logic [3:0] op, logic [3:0] idx, bit on = 0,
                                                logic [23:0] rgb = 0, logic [15:0] secs = 0,
                                                bit blink_en = 0, logic [15:0] half = 0,
                                                bit flag = 0);
      led_event_type e;
      e.operation = op;
      e.led_index = idx;
      e.turn_on = on;
      {e.red, e.green, e.blue} = rgb;
      e.timeout_seconds = secs;
      e.blink_enable = blink_en;
      e.blink_half_period = half;
      e.event_flag = flag;
      return e;
   endfunction

   task automatic send_op(logic [3:0] op, logic [3:0] idx = 0, bit flag = 0);
      send_event(make_event(op, idx, 0, 0, 0, 0, 0, flag));
   endtask

   task automatic drain();
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      drain();
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_BLINK_PERIOD: period_ms = value[15:0];
         REG_DEF_TIMEOUT:  def_tmo_ms = value[25:0];
         REG_TICK_MS:      tick_step = value[9:0];
         REG_BATT_COLOR:   batt_color = value[23:0];
         REG_ADV_COLOR:    adv_color = value[23:0];
         REG_PAIR_COLOR:   pair_color = value[23:0];
         default: ;
      endcase
   endtask

   task automatic setup_regs(int unsigned period, int unsigned tmo, int unsigned tick);
      write_reg(REG_BLINK_PERIOD, period);
      write_reg(REG_DEF_TIMEOUT, tmo);
      write_reg(REG_TICK_MS, tick);
      write_reg(REG_BATT_COLOR, $urandom);
      write_reg(REG_ADV_COLOR, $urandom);
      write_reg(REG_PAIR_COLOR, $urandom);
   endtask

   function automatic led_event_type random_event();
      led_event_type e;
      int pick;
      e = make_event(4'($urandom), 4'($urandom), 1'($urandom), 24'($urandom),
                     16'($urandom), 1'($urandom), 16'($urandom), 1'($urandom));
      pick = $urandom_range(99);
      if (pick < 35) e.operation = OP_TICK;
      else if (pick < 60) e.operation = OP_COMMAND;
      else if (pick < 67) e.operation = OP_SET_TMO;
      else if (pick < 75) e.operation = OP_QUERY;
      else if (pick < 97) e.operation = 4'($urandom_range(3, 8));
      else e.operation = 4'($urandom_range(10, 15));
      // mostly valid leds with short timers and blinks so expiries and toggles happen
      if ($urandom_range(99) < 85) begin
         e.led_index = 4'($urandom_range(0, LEDS - 1));
         e.timeout_seconds = 16'($urandom_range(0, 4));
         e.blink_half_period = 16'($urandom_range(0, 3000));
      end
      return e;
   endfunction

   task automatic test_queries();
      send_op(OP_QUERY, 0);
      send_op(OP_QUERY, 15);
      send_op(4'd10);
      send_op(4'd15, 15, 1);
   endtask

   task automatic test_commands();
      send_event(make_event(OP_COMMAND, 0, 1, 24'hFF00FF, 16'hFFFF, 1, 16'hFFFF));
      send_event(make_event(OP_COMMAND, 2, 0, 24'hFFFFFF, 16'hFFFF, 1, 16'hFFFF));
      send_event(make_event(OP_COMMAND, 3, 1, 24'h123456, 1, 1, 1));
      send_event(make_event(OP_COMMAND, 1, 1, 24'h00FF00, 0, 0, 0));
      send_event(make_event(OP_SET_TMO, 1, 0, 0, 0));
      send_event(make_event(OP_SET_TMO, 15, 0, 0, 7));
      send_op(OP_QUERY, 0);
      send_op(OP_QUERY, 1);
   endtask

   task automatic test_events();
      send_op(OP_BATTERY, 0, 1);
      send_event(make_event(OP_COMMAND, 0, 1, 24'hABCDEF, 3, 1, 40));
      send_op(OP_BATTERY, 0, 0);
      send_op(OP_CONNECT, 0, 0);
      send_op(OP_CONNECT, 0, 1);
      send_op(OP_CHARGE, 0, 1);
      send_op(OP_CHARGE, 0, 0);
      send_op(OP_PAIR_CF);
      send_op(OP_CONNECT, 0, 0);
      send_op(OP_PAIR_OK);
      send_op(OP_SLEEP, 0, 1);
      send_op(OP_SLEEP, 0, 0);
   endtask

   // one-second ticks: expiry, expiry swallowed at battery low, frozen time at zero tick
   task automatic test_expiry();
      setup_regs(1, 1, 1000);
      send_event(make_event(OP_COMMAND, 1, 1, 24'h0F0F0F, 2, 1, 0));
      send_event(make_event(OP_COMMAND, 2, 1, 24'h808080, 0, 1, 2500));
      repeat (3) send_op(OP_TICK);
      send_op(OP_BATTERY, 0, 1);
      send_event(make_event(OP_SET_TMO, 0, 0, 0, 1));
      repeat (3) send_op(OP_TICK);
      send_op(OP_QUERY, 0);
      setup_regs(65535, 65535000, 0);
      send_event(make_event(OP_COMMAND, 1, 1, 24'hFFFFFF, 1, 1, 1));
      repeat (2) send_op(OP_TICK);
   endtask

   task automatic run_random(int count);
      repeat (count) send_event(random_event());
   endtask

   task automatic test_random();
      setup_regs(500, 30000, 10);
      run_random(60);
      setup_regs($urandom_range(1, 3000), $urandom_range(1, 4000), 1000);
      run_random(90);
      no_idle = 1;
      setup_regs(65535, 65535000, $urandom_range(200, 999));
      run_random(70);
      no_idle = 0;
      setup_regs($urandom_range(1, 800), 1, $urandom_range(1, 500));
      run_random(60);
   endtask

   // receiver stalls long while events keep coming, so the core backs up into req_ready
   task automatic test_backpressure();
      setup_regs(500, 30000, 1000);
      hold_request = 400;
      run_random(25);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= '0;
      req_led_index <= '0;
      req_turn_on <= 1'b0;
      req_red <= '0;
      req_green <= '0;
      req_blue <= '0;
      req_timeout_seconds <= '0;
      req_blink_enable <= 1'b0;
      req_blink_half_period <= '0;
      req_event_flag <= 1'b0;
      rsp_ready <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      reset_predictor();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_queries();
      test_commands();
      test_events();
      test_expiry();
      test_random();
      test_backpressure();
      drain();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
